// ===== hdl/fesf_pkg.sv =====
// Shared types and constants for the flag/escape bit-stuffing framer.
// No dependencies; used by fesf_cell and flag_escape_stuffing_framer_top.
`default_nettype none

package fesf_pkg;

    // Symbol width limits and default
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int SYM_MAX         = 16;
    localparam int SYM_IDX_W       = 4;   // index into a SYM_MAX-bit vector
    localparam int CNT_W           = 7;   // holds 3*SYM_MAX and cell indexes

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC  = 2'd1;

    localparam logic [7:0] FLAG_RESET = 8'd64;
    localparam logic [7:0] ESC_RESET  = 8'd63;

    // Everything a cell needs to work out its own bit of a freshly loaded word run
    typedef struct packed {
        logic               open;    // opening flag leads the run
        logic               oldest;  // single bit shifted out of a full window
        logic [CNT_W-1:0]   b_len;   // 0, 1 or 2*S bits from the window check
        logic [CNT_W-1:0]   f_len;   // flushed window bits at frame end
        logic [CNT_W-1:0]   total;   // words in the run
        logic [SYM_MAX-1:0] flag;
        logic [SYM_MAX-1:0] esc;
        logic [SYM_MAX-1:0] wchk;    // matched window, sent after the escape
        logic [SYM_MAX-1:0] fwin;    // window left for flushing
    } t_load;

    // One stage of the output chain
    typedef struct packed {
        logic valid;
        logic line_bit;
        logic frame_done;
        logic run_last;
    } t_cell;

endpackage

`default_nettype wire

// ===== hdl/fesf_cell.sv =====
// One cell of the output shift chain: holds one output word, loads its own
// bit of a new run or takes the word of its upstream neighbor. Uses fesf_pkg.
`default_nettype none

module fesf_cell #(
    parameter int SYMBOL_BITS = 8,
    parameter int IDX         = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  wire                   i_shift,
    input  fesf_pkg::t_load       i_desc,
    input  fesf_pkg::t_cell       i_next,
    output fesf_pkg::t_cell       o_cell
);
    import fesf_pkg::*;

    localparam logic [CNT_W-1:0] K  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] S7 = CNT_W'(SYMBOL_BITS);

    t_cell            r_cell;
    t_cell            n_cell;
    t_cell            ld_cell;
    logic [CNT_W-1:0] a_len;
    logic [CNT_W-1:0] j1;
    logic [CNT_W-1:0] j2;
    logic [CNT_W-1:0] j3;
    logic             in_a;
    logic             in_b;
    logic             in_f;

    // Segment offsets: opening flag, window check, flush, closing flag
    always_comb begin
        a_len = i_desc.open ? S7 : '0;
        j1    = K - a_len;
        j2    = j1 - i_desc.b_len;
        j3    = j2 - i_desc.f_len;
        in_a  = K < a_len;
        in_b  = !in_a && (j1 < i_desc.b_len);
        in_f  = !in_a && !in_b && (j2 < i_desc.f_len);

        ld_cell.valid      = K < i_desc.total;
        ld_cell.run_last   = ld_cell.valid && (K == i_desc.total - 1'b1);
        ld_cell.frame_done = 1'b0;
        if (in_a) begin
            ld_cell.line_bit = i_desc.flag[SYM_IDX_W'(S7 - 1'b1 - K)];
        end else if (in_b) begin
            if (i_desc.b_len == CNT_W'(1)) begin
                ld_cell.line_bit = i_desc.oldest;
            end else if (j1 < S7) begin
                ld_cell.line_bit = i_desc.esc[SYM_IDX_W'(S7 - 1'b1 - j1)];
            end else begin
                ld_cell.line_bit = i_desc.wchk[SYM_IDX_W'((S7 << 1) - 1'b1 - j1)];
            end
        end else if (in_f) begin
            ld_cell.line_bit = i_desc.fwin[SYM_IDX_W'(i_desc.f_len - 1'b1 - j2)];
        end else begin
            ld_cell.line_bit   = i_desc.flag[SYM_IDX_W'(S7 - 1'b1 - j3)];
            ld_cell.frame_done = ld_cell.valid && (j3 == S7 - 1'b1);
        end
    end

    always_comb begin
        if (i_load) begin
            n_cell = ld_cell;
        end else if (i_shift) begin
            n_cell = i_next;
        end else begin
            n_cell = r_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ===== hdl/flag_escape_stuffing_framer_top.sv =====
// Top level of the flag/escape bit-stuffing framer: config registers,
// look-ahead window and a row of fesf_cell output stages. Uses fesf_pkg.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+----------------------------------
//   in      | i_in_valid  | o_in_ready  | i_data_bit, i_frame_last
//   out     | o_out_valid | i_out_ready | o_line_bit, o_frame_done, o_run_last
//   cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// An input word producing n output words occupies n cells of the output chain,
// one word leaving per cycle from the head cell (a register). n is 0..3*SYMBOL_BITS.
// The next input word is taken in the cycle the last pending output word leaves,
// so a one-bit result sustains one input word per cycle; words with no result
// are taken whenever the chain is empty or draining its last word.
// Reset (synchronous, active low) closes the frame, empties the window and the
// chain, and restores the flag and escape registers. Output stalls hold the chain.
`default_nettype none

module flag_escape_stuffing_framer_top #(
    parameter int SYMBOL_BITS = fesf_pkg::SYMBOL_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input words
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_data_bit,
    input  wire                              i_frame_last,
    // output words
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_line_bit,
    output logic                             o_frame_done,
    output logic                             o_run_last,
    // configuration
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [fesf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [7:0]                        i_cfg_data
);
    import fesf_pkg::*;

    localparam int NCELL = 3 * SYMBOL_BITS;          // longest run: escape+window+flag
    localparam int FW    = $clog2(SYMBOL_BITS + 1);
    localparam logic [FW-1:0]    S_FILL = FW'(SYMBOL_BITS);
    localparam logic [CNT_W-1:0] S_CNT  = CNT_W'(SYMBOL_BITS);

    // Config registers
    logic [7:0]             r_flag;
    logic [7:0]             r_esc;

    // Window state: newest bit in bit 0, bits above the fill level are zero
    logic [SYMBOL_BITS-1:0] r_win;
    logic [FW-1:0]          r_fill;
    logic                   r_in_frame;
    logic [SYMBOL_BITS-1:0] n_win;
    logic [FW-1:0]          n_fill;
    logic                   n_in_frame;

    logic [SYM_MAX-1:0]     flag_x;
    logic [SYM_MAX-1:0]     esc_x;
    logic [SYMBOL_BITS-1:0] flag_s;
    logic [SYMBOL_BITS-1:0] esc_s;
    logic [SYMBOL_BITS-1:0] win_eff;
    logic [FW-1:0]          fill_eff;
    logic [SYMBOL_BITS-1:0] w_new;
    logic [FW-1:0]          fill_new;
    logic                   full;
    logic                   match;
    logic [SYMBOL_BITS-1:0] win_chk;
    logic [FW-1:0]          fill_chk;
    logic                   in_acc;
    logic                   out_acc;
    t_load                  desc;
    t_cell                  chain [NCELL];

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= FLAG_RESET;
            r_esc  <= ESC_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FLAG: r_flag <= i_cfg_data;
                CFG_ESC:  r_esc  <= i_cfg_data;
                default: ;   // unmapped index, ignored
            endcase
        end
    end

    // Patterns use the low SYMBOL_BITS bits, zero above bit 7
    assign flag_x = {{(SYM_MAX-8){1'b0}}, r_flag};
    assign esc_x  = {{(SYM_MAX-8){1'b0}}, r_esc};
    assign flag_s = flag_x[SYMBOL_BITS-1:0];
    assign esc_s  = esc_x[SYMBOL_BITS-1:0];

    // ---------------- handshakes ----------------
    // Head cell is the output register; a new run loads once the chain is
    // empty or its last word leaves this cycle.
    assign o_out_valid = chain[0].valid;
    assign o_line_bit  = chain[0].line_bit;
    assign o_frame_done = chain[0].frame_done;
    assign o_run_last  = chain[0].run_last;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = !chain[0].valid || (!chain[1].valid && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    // ---------------- window check ----------------
    always_comb begin
        // a new frame starts from an empty window
        win_eff  = r_in_frame ? r_win  : '0;
        fill_eff = r_in_frame ? r_fill : '0;
        w_new    = {win_eff[SYMBOL_BITS-2:0], i_data_bit};
        fill_new = fill_eff + 1'b1;
        full     = (fill_new == S_FILL);
        match    = full && ((w_new == flag_s) || (w_new == esc_s));

        if (match) begin
            win_chk  = '0;
            fill_chk = '0;
        end else if (full) begin
            win_chk  = {1'b0, w_new[SYMBOL_BITS-2:0]};   // oldest bit goes out
            fill_chk = S_FILL - 1'b1;
        end else begin
            win_chk  = w_new;
            fill_chk = fill_new;
        end

        desc.open   = !r_in_frame;
        desc.oldest = w_new[SYMBOL_BITS-1];
        desc.b_len  = match ? (S_CNT << 1) : (full ? CNT_W'(1) : '0);
        desc.f_len  = i_frame_last ? CNT_W'(fill_chk) : '0;
        desc.total  = (desc.open ? S_CNT : '0) + desc.b_len
                    + (i_frame_last ? (desc.f_len + S_CNT) : '0);
        desc.flag   = SYM_MAX'(flag_s);
        desc.esc    = SYM_MAX'(esc_s);
        desc.wchk   = SYM_MAX'(w_new);
        desc.fwin   = SYM_MAX'(win_chk);

        // closing flag ends the frame and empties the window
        n_win      = i_frame_last ? '0 : win_chk;
        n_fill     = i_frame_last ? '0 : fill_chk;
        n_in_frame = !i_frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_fill     <= '0;
            r_in_frame <= 1'b0;
        end else if (in_acc) begin
            r_win      <= n_win;
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
        end
    end

    // ---------------- output chain ----------------
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        t_cell up;
        if (k == NCELL - 1) begin : g_end
            assign up = '0;
        end else begin : g_mid
            assign up = chain[k+1];
        end
        fesf_cell #(
            .SYMBOL_BITS (SYMBOL_BITS),
            .IDX         (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (in_acc),
            .i_shift (out_acc),
            .i_desc  (desc),
            .i_next  (up),
            .o_cell  (chain[k])
        );
    end

    // ---------------- assertions ----------------
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_run_last)
        else $error("closing flag bit not marked as end of run");

    a_fill_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < S_FILL)
        else $error("window left full after a step");

    a_idle_window_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_fill == '0) && (r_win == '0))
        else $error("window not empty outside a frame");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_frame_last |=> !r_in_frame && o_out_valid)
        else $error("frame end did not close the frame");

    a_gap_free_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !chain[0].valid |-> !chain[1].valid)
        else $error("hole at the head of the output chain");

endmodule

`default_nettype wire
